FILE: rtl/lsps_pkg.sv
// ----------------------------------------------------------------------------
// lsps_pkg
// Shared types, constants and widths for the line sensor PID steering block.
// ----------------------------------------------------------------------------
package lsps_pkg;

  // Running error sum width and gain fraction bits
  localparam int SUM_WIDTH      = 16;
  localparam int GAIN_FRAC_BITS = 12;

  localparam int GAIN_W   = 20;
  localparam int DUTY_W   = 16;
  localparam int HITS_W   = 5;
  localparam int ERR_W    = 4;
  localparam int DELTA_W  = ERR_W + 1;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = GAIN_W;

  // Product and accumulator widths (signed)
  localparam int PROD_P_W = GAIN_W + 1 + ERR_W;
  localparam int PROD_I_W = GAIN_W + 1 + SUM_WIDTH;
  localparam int PROD_D_W = GAIN_W + 1 + DELTA_W;
  localparam int ACC_W    = PROD_I_W + 2;
  localparam int CORR_W   = ACC_W - GAIN_FRAC_BITS;
  localparam int MIX_W    = ((CORR_W > DUTY_W + 1) ? CORR_W : DUTY_W + 1) + 1;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_PROP  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_INTEG = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_DERIV = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_DUTY  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DUTY_TOP   = 3'd4;

  // Register reset values
  localparam logic [GAIN_W-1:0] GAIN_PROP_RST  = 20'd204800;
  localparam logic [GAIN_W-1:0] GAIN_INTEG_RST = 20'd41;
  localparam logic [GAIN_W-1:0] GAIN_DERIV_RST = 20'd2048;
  localparam logic [DUTY_W-1:0] BASE_DUTY_RST  = 16'd300;
  localparam logic [DUTY_W-1:0] DUTY_TOP_RST   = 16'd737;

  // Position error codes
  localparam logic signed [ERR_W-1:0] ERR_FAR_LEFT   = -4'sd4;
  localparam logic signed [ERR_W-1:0] ERR_LEFT_PAIR  = -4'sd3;
  localparam logic signed [ERR_W-1:0] ERR_LEFT       = -4'sd2;
  localparam logic signed [ERR_W-1:0] ERR_CENTER_L   = -4'sd1;
  localparam logic signed [ERR_W-1:0] ERR_CENTER     =  4'sd0;
  localparam logic signed [ERR_W-1:0] ERR_CENTER_R   =  4'sd1;
  localparam logic signed [ERR_W-1:0] ERR_RIGHT      =  4'sd2;
  localparam logic signed [ERR_W-1:0] ERR_RIGHT_PAIR =  4'sd3;
  localparam logic signed [ERR_W-1:0] ERR_FAR_RIGHT  =  4'sd4;

  typedef struct packed {
    logic [GAIN_W-1:0] gain_prop;
    logic [GAIN_W-1:0] gain_integ;
    logic [GAIN_W-1:0] gain_deriv;
    logic [DUTY_W-1:0] base_duty;
    logic [DUTY_W-1:0] duty_top;
  } cfg_t;

endpackage

FILE: rtl/lsps_cfg.sv
// ----------------------------------------------------------------------------
// lsps_cfg
// Configuration registers: gains, base duty and PWM top.
// ----------------------------------------------------------------------------
module lsps_cfg
  import lsps_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output cfg_t                  cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_GAIN_PROP:  cfg_d.gain_prop  = cfg_data_i[GAIN_W-1:0];
        CFG_GAIN_INTEG: cfg_d.gain_integ = cfg_data_i[GAIN_W-1:0];
        CFG_GAIN_DERIV: cfg_d.gain_deriv = cfg_data_i[GAIN_W-1:0];
        CFG_BASE_DUTY:  cfg_d.base_duty  = cfg_data_i[DUTY_W-1:0];
        CFG_DUTY_TOP:   cfg_d.duty_top   = cfg_data_i[DUTY_W-1:0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gain_prop  <= GAIN_PROP_RST;
      cfg_q.gain_integ <= GAIN_INTEG_RST;
      cfg_q.gain_deriv <= GAIN_DERIV_RST;
      cfg_q.base_duty  <= BASE_DUTY_RST;
      cfg_q.duty_top   <= DUTY_TOP_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: rtl/lsps_decode.sv
// ----------------------------------------------------------------------------
// lsps_decode
// Priority decoder from five sensor hits to a signed position error.
// ----------------------------------------------------------------------------
module lsps_decode
  import lsps_pkg::*;
(
  input  logic [HITS_W-1:0]       hits_i,
  input  logic signed [ERR_W-1:0] held_i,
  output logic signed [ERR_W-1:0] err_o
);

  // adjacent pairs win over single sensors
  always_comb begin
    if (hits_i[0] && hits_i[1])      err_o = ERR_LEFT_PAIR;
    else if (hits_i[1] && hits_i[2]) err_o = ERR_CENTER_L;
    else if (hits_i[2] && hits_i[3]) err_o = ERR_CENTER_R;
    else if (hits_i[3] && hits_i[4]) err_o = ERR_RIGHT_PAIR;
    else if (hits_i[4])              err_o = ERR_FAR_RIGHT;
    else if (hits_i[0])              err_o = ERR_FAR_LEFT;
    else if (hits_i[3])              err_o = ERR_RIGHT;
    else if (hits_i[2])              err_o = ERR_CENTER;
    else if (hits_i[1])              err_o = ERR_LEFT;
    else                             err_o = held_i;
  end

endmodule

FILE: rtl/lsps_pid.sv
// ----------------------------------------------------------------------------
// lsps_pid
// PID correction in fixed point, ceiling rounding, duty mix and clamp,
// and the saturating update of the error sum.
// ----------------------------------------------------------------------------
module lsps_pid
  import lsps_pkg::*;
(
  input  cfg_t                        cfg_i,
  input  logic signed [ERR_W-1:0]     err_i,
  input  logic signed [ERR_W-1:0]     last_err_i,
  input  logic signed [SUM_WIDTH-1:0] sum_i,
  output logic [DUTY_W-1:0]           left_duty_o,
  output logic [DUTY_W-1:0]           right_duty_o,
  output logic signed [SUM_WIDTH-1:0] sum_next_o
);

  localparam logic [ACC_W-1:0] ROUND_UP = {{(ACC_W-GAIN_FRAC_BITS){1'b0}},
                                           {GAIN_FRAC_BITS{1'b1}}};
  localparam logic signed [SUM_WIDTH-1:0] SUM_MAX = {1'b0, {(SUM_WIDTH-1){1'b1}}};
  localparam logic signed [SUM_WIDTH-1:0] SUM_MIN = {1'b1, {(SUM_WIDTH-1){1'b0}}};

  logic signed [GAIN_W:0]         gp_s, gi_s, gd_s;
  logic signed [DELTA_W-1:0]      delta;
  logic signed [PROD_P_W-1:0]     prod_p;
  logic signed [PROD_I_W-1:0]     prod_i;
  logic signed [PROD_D_W-1:0]     prod_d;
  logic signed [ACC_W-1:0]        acc;
  logic signed [ACC_W-1:0]        acc_rnd;
  logic signed [CORR_W-1:0]       corr;
  logic signed [MIX_W-1:0]        corr_x, base_x, top_x;
  logic signed [MIX_W-1:0]        left_mix, right_mix;
  logic signed [SUM_WIDTH:0]      sum_wide;

  function automatic logic [DUTY_W-1:0] clamp_duty(logic signed [MIX_W-1:0] v,
                                                   logic signed [MIX_W-1:0] top);
    logic [DUTY_W-1:0] r;
    if (v[MIX_W-1])  r = '0;
    else if (v > top) r = top[DUTY_W-1:0];
    else             r = v[DUTY_W-1:0];
    return r;
  endfunction

  always_comb begin
    gp_s  = $signed({1'b0, cfg_i.gain_prop});
    gi_s  = $signed({1'b0, cfg_i.gain_integ});
    gd_s  = $signed({1'b0, cfg_i.gain_deriv});
    delta = $signed({err_i[ERR_W-1], err_i}) - $signed({last_err_i[ERR_W-1], last_err_i});

    prod_p = gp_s * err_i;
    prod_i = gi_s * sum_i;
    prod_d = gd_s * delta;

    acc = $signed({{(ACC_W-PROD_P_W){prod_p[PROD_P_W-1]}}, prod_p})
        + $signed({{(ACC_W-PROD_I_W){prod_i[PROD_I_W-1]}}, prod_i})
        + $signed({{(ACC_W-PROD_D_W){prod_d[PROD_D_W-1]}}, prod_d});

    // ceiling divide: add 2^F-1 then arithmetic shift
    acc_rnd = acc + $signed(ROUND_UP);
    corr    = acc_rnd[ACC_W-1:GAIN_FRAC_BITS];

    corr_x = $signed({{(MIX_W-CORR_W){corr[CORR_W-1]}}, corr});
    base_x = $signed({{(MIX_W-DUTY_W){1'b0}}, cfg_i.base_duty});
    top_x  = $signed({{(MIX_W-DUTY_W){1'b0}}, cfg_i.duty_top});

    left_mix  = base_x - corr_x;
    right_mix = base_x + corr_x;

    left_duty_o  = clamp_duty(left_mix, top_x);
    right_duty_o = clamp_duty(right_mix, top_x);

    sum_wide = $signed({sum_i[SUM_WIDTH-1], sum_i})
             + $signed({{(SUM_WIDTH+1-ERR_W){err_i[ERR_W-1]}}, err_i});
    if (sum_wide[SUM_WIDTH] != sum_wide[SUM_WIDTH-1]) begin
      sum_next_o = sum_wide[SUM_WIDTH] ? SUM_MIN : SUM_MAX;
    end else begin
      sum_next_o = sum_wide[SUM_WIDTH-1:0];
    end
  end

endmodule

FILE: rtl/line_sensor_pid_steering.sv
// ----------------------------------------------------------------------------
// line_sensor_pid_steering
// Path: input register holds the sensor word, result register its result.
// Throughput: one word per cycle unless the output stalls; the decode, PID
// multiply-add and clamp sit in one pass between the two registers.
// Reset: async active low; clears valids, last error, error sum and loads
// the default gains, base duty and PWM top.
// ----------------------------------------------------------------------------
module line_sensor_pid_steering
  import lsps_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [HITS_W-1:0]      sensor_hits_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [DUTY_W-1:0]      left_duty_o,
  output logic [DUTY_W-1:0]      right_duty_o,
  output logic signed [ERR_W-1:0] position_error_o,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i
);

  cfg_t cfg;

  logic                        in_valid_q;
  logic [HITS_W-1:0]           hits_q;
  logic                        out_valid_q;
  logic [DUTY_W-1:0]           left_q, right_q;
  logic signed [ERR_W-1:0]     perr_q;
  logic signed [ERR_W-1:0]     last_err_q;
  logic signed [SUM_WIDTH-1:0] sum_q;

  logic signed [ERR_W-1:0]     err;
  logic [DUTY_W-1:0]           left_d, right_d;
  logic signed [SUM_WIDTH-1:0] sum_d;
  logic                        advance, in_take;

  lsps_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  lsps_decode u_decode (
    .hits_i (hits_q),
    .held_i (last_err_q),
    .err_o  (err)
  );

  lsps_pid u_pid (
    .cfg_i        (cfg),
    .err_i        (err),
    .last_err_i   (last_err_q),
    .sum_i        (sum_q),
    .left_duty_o  (left_d),
    .right_duty_o (right_d),
    .sum_next_o   (sum_d)
  );

  // word moves to the result register when that slot is free or draining
  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      last_err_q  <= '0;
      sum_q       <= '0;
    end else begin
      if (in_take) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        last_err_q  <= err;
        sum_q       <= sum_d;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      hits_q <= sensor_hits_i;
    end
    if (advance) begin
      left_q  <= left_d;
      right_q <= right_d;
      perr_q  <= err;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign left_duty_o      = left_q;
  assign right_duty_o     = right_q;
  assign position_error_o = perr_q;

endmodule
